// ===== rtl/core/rdds_pkg.sv =====
// shared widths, register indexes and defaults for the ray setup block
package rdds_pkg;

  localparam int COL_W   = 10;
  localparam int POS_W   = 26;
  localparam int VEC_W   = 18;
  localparam int RAY_W   = 19;
  localparam int CELL_W  = 10;
  localparam int DIST_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam int SCREEN_WIDTH_DEF = 1024;
  localparam int MAP_CELLS_DEF    = 1024;

  // reciprocal divider: 36 quotient bits, 4 per stage
  localparam int DIV_BITS = 4;
  localparam int DIV_QW   = 36;
  localparam int DIV_ST   = DIV_QW / DIV_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_t;

endpackage

// ===== rtl/core/rdds_in_if.sv =====
// column word channel into the ray setup block
interface rdds_in_if
  import rdds_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink   (input valid, input column, output ready);
endinterface

// ===== rtl/core/rdds_out_if.sv =====
// ray setup result word channel
interface rdds_out_if
  import rdds_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [RAY_W-1:0]  ray_dx;
  logic signed [RAY_W-1:0]  ray_dy;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_y;
  logic                     step_x_neg;
  logic                     step_y_neg;
  logic [DIST_W-1:0]        delta_x;
  logic [DIST_W-1:0]        delta_y;
  logic [DIST_W-1:0]        side_x;
  logic [DIST_W-1:0]        side_y;

  modport source (output valid, output ray_dx, output ray_dy, output cell_x, output cell_y,
                  output step_x_neg, output step_y_neg, output delta_x, output delta_y,
                  output side_x, output side_y, input ready);
  modport sink   (input valid, input ray_dx, input ray_dy, input cell_x, input cell_y,
                  input step_x_neg, input step_y_neg, input delta_x, input delta_y,
                  input side_x, input side_y, output ready);
endinterface

// ===== rtl/core/raycast_dda_setup_unit.sv =====
// Ray setup for a grid raycaster: one column word in, one ray word out. The block is a
// 14-stage pipeline and takes one column per cycle while the output is not stalled. Camera
// offset, ray products, ray sum, nine stages of a 4-bit-per-stage reciprocal divider, the
// side-distance multiply and the output register each own one stage. Each stage holds its
// word until the next stage frees up, so bubbles close up under backpressure. The user must
// write viewer registers through the cfg port only while the pipeline is empty; the block
// itself does not enforce this.
module raycast_dda_setup_unit
  import rdds_pkg::*;
#(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  parameter int MAP_CELLS    = MAP_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rdds_in_if.sink              in_if,
  rdds_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [POS_W-1:0]     cfg_data
);

  localparam int NST     = DIV_ST + 5;
  localparam int SW_LOG  = $clog2(SCREEN_WIDTH);
  localparam int CAM_K   = 27 + SW_LOG;
  localparam int CAM_SH  = CAM_K - 17;
  localparam longint unsigned CAM_M =
    ((64'd1 << CAM_K) + longint'(SCREEN_WIDTH) - 1) / longint'(SCREEN_WIDTH);
  localparam logic [DIV_QW-1:0] DIVIDEND = 36'h1_0000_0000;
  localparam logic [16:0] CELL_MAX = 17'(MAP_CELLS - 1);
  localparam logic [12:0] COL_MAX  = 13'(SCREEN_WIDTH - 1);

  typedef struct packed {
    logic signed [RAY_W-1:0] rx;
    logic signed [RAY_W-1:0] ry;
    logic [CELL_W-1:0]       cx;
    logic [CELL_W-1:0]       cy;
    logic                    nx;
    logic                    ny;
    logic [POS_W-1:0]        offx;
    logic [POS_W-1:0]        offy;
    logic [VEC_W-1:0]        mx;
    logic [VEC_W-1:0]        my;
    logic [VEC_W-1:0]        remx;
    logic [VEC_W-1:0]        remy;
    logic [DIV_QW-1:0]       qx;
    logic [DIV_QW-1:0]       qy;
  } div_t;

  // configuration
  logic [POS_W-1:0]        pos_x_r, pos_y_r;
  logic signed [VEC_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      dir_x_r   <= 18'sd65536;
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= 18'sd43253;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_POS_X:   pos_x_r   <= cfg_data;
        CFG_POS_Y:   pos_y_r   <= cfg_data;
        CFG_DIR_X:   dir_x_r   <= cfg_data[VEC_W-1:0];
        CFG_DIR_Y:   dir_y_r   <= cfg_data[VEC_W-1:0];
        CFG_PLANE_X: plane_x_r <= cfg_data[VEC_W-1:0];
        CFG_PLANE_Y: plane_y_r <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_if.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_if.valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0: column to camera offset, division by screen width as reciprocal multiply
  logic [COL_W-1:0]        col_c;
  logic [38:0]             cam_prod;
  logic [17:0]             cam_q;
  logic signed [VEC_W-1:0] cam_r, cam_nxt;

  always_comb begin
    col_c    = (13'(in_if.column) > COL_MAX) ? COL_MAX[COL_W-1:0] : in_if.column;
    cam_prod = 39'(col_c) * 39'(CAM_M);
    cam_q    = 18'(cam_prod >> CAM_SH);
    cam_nxt  = VEC_W'(cam_q - 18'd65536);
  end

  always_ff @(posedge clk) begin
    if (en[0]) cam_r <= cam_nxt;
  end

  // stage 1: plane times camera offset
  logic signed [35:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px_r <= plane_x_r * cam_r;
      py_r <= plane_y_r * cam_r;
    end
  end

  // stage 2: ray sum with saturation, cell, step sign, grid offset
  div_t ds_r [DIV_ST+1];
  div_t ds0_nxt;

  function automatic logic signed [RAY_W-1:0] ray_sat(input logic signed [VEC_W-1:0] d,
                                                      input logic signed [35:0] p);
    logic signed [20:0] s;
    s = 21'(d) + 21'(p >>> 16);
    if (s > 21'sd131072) s = 21'sd131072;
    else if (s < -21'sd131072) s = -21'sd131072;
    return s[RAY_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic [POS_W-1:0] pos);
    logic [CELL_W-1:0] c;
    c = pos[POS_W-1:16];
    if (17'(c) > CELL_MAX) c = CELL_MAX[CELL_W-1:0];
    return c;
  endfunction

  function automatic logic [POS_W-1:0] off_of(input logic [POS_W-1:0] pos,
                                              input logic [CELL_W-1:0] c,
                                              input logic neg);
    logic [26:0] base;
    logic [26:0] o;
    base = {1'b0, c, 16'd0};
    if (neg) begin
      o = {1'b0, pos} - base;
    end else begin
      base = base + 27'd65536;
      o = (base > {1'b0, pos}) ? base - {1'b0, pos} : '0;
    end
    return o[POS_W-1:0];
  endfunction

  always_comb begin
    ds0_nxt      = '0;
    ds0_nxt.rx   = ray_sat(dir_x_r, px_r);
    ds0_nxt.ry   = ray_sat(dir_y_r, py_r);
    ds0_nxt.nx   = (ds0_nxt.rx <= 0);
    ds0_nxt.ny   = (ds0_nxt.ry <= 0);
    ds0_nxt.mx   = ds0_nxt.rx[RAY_W-1] ? VEC_W'(-ds0_nxt.rx) : VEC_W'(ds0_nxt.rx);
    ds0_nxt.my   = ds0_nxt.ry[RAY_W-1] ? VEC_W'(-ds0_nxt.ry) : VEC_W'(ds0_nxt.ry);
    ds0_nxt.cx   = cell_of(pos_x_r);
    ds0_nxt.cy   = cell_of(pos_y_r);
    ds0_nxt.offx = off_of(pos_x_r, ds0_nxt.cx, ds0_nxt.nx);
    ds0_nxt.offy = off_of(pos_y_r, ds0_nxt.cy, ds0_nxt.ny);
  end

  always_ff @(posedge clk) begin
    if (en[2]) ds_r[0] <= ds0_nxt;
  end

  // divider stages: restoring division of 2^32 by |ray|, 4 quotient bits each
  for (genvar j = 0; j < DIV_ST; j++) begin : g_div
    div_t dn;

    always_comb begin
      logic [VEC_W:0] shx, shy;
      dn = ds_r[j];
      for (int k = 0; k < DIV_BITS; k++) begin
        shx = {dn.remx, DIVIDEND[DIV_QW-1-DIV_BITS*j-k]};
        shy = {dn.remy, DIVIDEND[DIV_QW-1-DIV_BITS*j-k]};
        if (shx >= {1'b0, dn.mx}) begin
          dn.remx = VEC_W'(shx - {1'b0, dn.mx});
          dn.qx   = {dn.qx[DIV_QW-2:0], 1'b1};
        end else begin
          dn.remx = shx[VEC_W-1:0];
          dn.qx   = {dn.qx[DIV_QW-2:0], 1'b0};
        end
        if (shy >= {1'b0, dn.my}) begin
          dn.remy = VEC_W'(shy - {1'b0, dn.my});
          dn.qy   = {dn.qy[DIV_QW-2:0], 1'b1};
        end else begin
          dn.remy = shy[VEC_W-1:0];
          dn.qy   = {dn.qy[DIV_QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[3+j]) ds_r[j+1] <= dn;
    end
  end

  // multiply stage: saturate reciprocal, offset times delta
  localparam int MS = DIV_ST + 3;
  div_t              dl;
  logic [DIST_W-1:0] dx_nxt, dy_nxt;
  logic [DIST_W-1:0] dx_r, dy_r;
  logic [57:0]       sxp_r, syp_r;
  logic signed [RAY_W-1:0] mrx_r, mry_r;
  logic [CELL_W-1:0] mcx_r, mcy_r;
  logic              mnx_r, mny_r;

  always_comb begin
    dl     = ds_r[DIV_ST];
    dx_nxt = (dl.qx[DIV_QW-1:DIST_W] != '0) ? '1 : dl.qx[DIST_W-1:0];
    dy_nxt = (dl.qy[DIV_QW-1:DIST_W] != '0) ? '1 : dl.qy[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[MS]) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      sxp_r <= 58'(dl.offx) * 58'(dx_nxt);
      syp_r <= 58'(dl.offy) * 58'(dy_nxt);
      mrx_r <= dl.rx;
      mry_r <= dl.ry;
      mcx_r <= dl.cx;
      mcy_r <= dl.cy;
      mnx_r <= dl.nx;
      mny_r <= dl.ny;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[MS+1]) begin
      out_if.ray_dx     <= mrx_r;
      out_if.ray_dy     <= mry_r;
      out_if.cell_x     <= mcx_r;
      out_if.cell_y     <= mcy_r;
      out_if.step_x_neg <= mnx_r;
      out_if.step_y_neg <= mny_r;
      out_if.delta_x    <= dx_r;
      out_if.delta_y    <= dy_r;
      out_if.side_x     <= (sxp_r[57:48] != '0) ? '1 : sxp_r[47:16];
      out_if.side_y     <= (syp_r[57:48] != '0) ? '1 : syp_r[47:16];
    end
  end

  assign out_if.valid = v_r[NST-1];

endmodule

// ===== tb/tb_ifaces.sv =====
// ray word type held by the testbench scoreboard
package tb_ray_pkg;
  import rdds_pkg::*;

  typedef struct {
    logic signed [RAY_W-1:0] ray_dx;
    logic signed [RAY_W-1:0] ray_dy;
    logic [CELL_W-1:0]       cell_x;
    logic [CELL_W-1:0]       cell_y;
    logic                    step_x_neg;
    logic                    step_y_neg;
    logic [DIST_W-1:0]       delta_x;
    logic [DIST_W-1:0]       delta_y;
    logic [DIST_W-1:0]       side_x;
    logic [DIST_W-1:0]       side_y;
  } ray_word_t;

endpackage

// ===== tb/tb_top.sv =====
// testbench for raycast_dda_setup_unit: random columns and viewer setups, scoreboard check
module tb_top
  import rdds_pkg::*, tb_ray_pkg::*;
  ();

  localparam int SCR_W = 1024;
  localparam int MAP_N = 1024;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [POS_W-1:0] cfg_data = '0;
  int errors = 0;
  int cols_sent = 0;
  int rays_seen = 0;
  int idle_cycles = 0;
  int setups = 0;
  bit in_gaps = 1'b1;
  bit out_stalls = 1'b1;

  always #5 clk = ~clk;

  rdds_in_if  col_ch ();
  rdds_out_if ray_ch ();

  raycast_dda_setup_unit uut (
    .clk(clk), .rst_n(rst_n), .in_if(col_ch), .out_if(ray_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  class ray_scoreboard;
    logic [POS_W-1:0] pos_x, pos_y;
    logic signed [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;
    ray_word_t pending[$];

    function void set_defaults();
      pos_x = '0; pos_y = '0;
      dir_x = 18'sd65536; dir_y = '0;
      plane_x = '0; plane_y = 18'sd43253;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [POS_W-1:0] v);
      case (idx)
        CFG_POS_X:   pos_x = v;
        CFG_POS_Y:   pos_y = v;
        CFG_DIR_X:   dir_x = v[VEC_W-1:0];
        CFG_DIR_Y:   dir_y = v[VEC_W-1:0];
        CFG_PLANE_X: plane_x = v[VEC_W-1:0];
        CFG_PLANE_Y: plane_y = v[VEC_W-1:0];
        default: ;
      endcase
    endfunction

    // floor of a signed value over 2^16
    function longint floor16(longint v);
      if (v >= 0) return v >>> 16;
      return -((-v + 65535) >>> 16);
    endfunction

    function longint ray_comp(longint d, longint p, longint cam);
      longint r;
      r = d + floor16(p * cam);
      if (r > 131072) r = 131072;
      if (r < -131072) r = -131072;
      return r;
    endfunction

    function void axis_setup(longint pos, longint r, output logic [CELL_W-1:0] cell_o,
                             output logic neg, output logic [DIST_W-1:0] delta,
                             output logic [DIST_W-1:0] side);
      longint c, base, off, d, s, m;
      c = pos >> 16;
      if (c > MAP_N - 1) c = MAP_N - 1;
      if (r == 0) d = 64'hFFFF_FFFF;
      else begin
        m = (r < 0) ? -r : r;
        d = (longint'(1) << 32) / m;
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
      end
      base = c * 65536;
      if (r <= 0) off = (pos >= base) ? pos - base : 0;
      else begin
        base += 65536;
        off = (base > pos) ? base - pos : 0;
      end
      if (off > 64'h3FF_FFFF) off = 64'h3FF_FFFF;
      s = (off * d) >>> 16;
      if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      cell_o = c[CELL_W-1:0];
      neg = (r <= 0);
      delta = d[DIST_W-1:0];
      side = s[DIST_W-1:0];
    endfunction

    function void note_column(logic [COL_W-1:0] column);
      ray_word_t w;
      longint col, cam, rx, ry;
      col = column;
      if (col >= SCR_W) col = SCR_W - 1;
      cam = (2 * col * 65536) / SCR_W - 65536;
      rx = ray_comp(dir_x, plane_x, cam);
      ry = ray_comp(dir_y, plane_y, cam);
      w.ray_dx = rx[RAY_W-1:0];
      w.ray_dy = ry[RAY_W-1:0];
      axis_setup(pos_x, rx, w.cell_x, w.step_x_neg, w.delta_x, w.side_x);
      axis_setup(pos_y, ry, w.cell_y, w.step_y_neg, w.delta_y, w.side_y);
      pending.push_back(w);
    endfunction

    task check_ray(ray_word_t got);
      ray_word_t e;
      if (pending.size() == 0) begin
        report("unexpected ray word", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.ray_dx !== e.ray_dx) report("ray_dx", got.ray_dx, e.ray_dx);
      if (got.ray_dy !== e.ray_dy) report("ray_dy", got.ray_dy, e.ray_dy);
      if (got.cell_x !== e.cell_x) report("cell_x", got.cell_x, e.cell_x);
      if (got.cell_y !== e.cell_y) report("cell_y", got.cell_y, e.cell_y);
      if (got.step_x_neg !== e.step_x_neg) report("step_x_neg", got.step_x_neg, e.step_x_neg);
      if (got.step_y_neg !== e.step_y_neg) report("step_y_neg", got.step_y_neg, e.step_y_neg);
      if (got.delta_x !== e.delta_x) report("delta_x", got.delta_x, e.delta_x);
      if (got.delta_y !== e.delta_y) report("delta_y", got.delta_y, e.delta_y);
      if (got.side_x !== e.side_x) report("side_x", got.side_x, e.side_x);
      if (got.side_y !== e.side_y) report("side_y", got.side_y, e.side_y);
    endtask
  endclass

  ray_scoreboard sb = new();

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random ready, sample at the edge
  initial begin
    int hold;
    ray_ch.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && ray_ch.valid && ray_ch.ready) begin
        ray_word_t g;
        g.ray_dx = ray_ch.ray_dx; g.ray_dy = ray_ch.ray_dy;
        g.cell_x = ray_ch.cell_x; g.cell_y = ray_ch.cell_y;
        g.step_x_neg = ray_ch.step_x_neg; g.step_y_neg = ray_ch.step_y_neg;
        g.delta_x = ray_ch.delta_x; g.delta_y = ray_ch.delta_y;
        g.side_x = ray_ch.side_x; g.side_y = ray_ch.side_y;
        sb.check_ray(g);
        rays_seen++;
      end
      if (hold > 0) begin
        hold--;
        ray_ch.ready <= 1'b0;
      end else if (out_stalls && gap_len() != 0) begin
        hold = gap_len();
        ray_ch.ready <= 1'b0;
      end else begin
        ray_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((col_ch.valid && col_ch.ready) || (ray_ch.valid && ray_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress, %0d rays still expected", sb.pending.size());
      $display("FAIL raycast_dda_setup_unit");
      $finish;
    end
  end

  // valid stays high across back-to-back words and drops for a gap (drain also drops it)
  task automatic send_column(input logic [COL_W-1:0] column);
    int g;
    g = in_gaps ? gap_len() : 0;
    if (g > 0) begin
      col_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    col_ch.valid <= 1'b1;
    col_ch.column <= column;
    do @(posedge clk); while (!col_ch.ready);
    sb.note_column(column);
    cols_sent++;
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [POS_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    col_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] rand_vec();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return POS_W'(65536);
      1: return POS_W'(-65536);
      2: return '0;
      3: return POS_W'(1);
      4: return POS_W'(-1);
      default: return POS_W'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return '0;
      1: return '1;
      2: return POS_W'($urandom_range(0, 1023)) << 16;
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic load_setup(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [POS_W-1:0] dx, input logic [POS_W-1:0] dy,
                            input logic [POS_W-1:0] plx, input logic [POS_W-1:0] ply);
    write_cfg(CFG_POS_X, px);
    write_cfg(CFG_POS_Y, py);
    write_cfg(CFG_DIR_X, dx);
    write_cfg(CFG_DIR_Y, dy);
    write_cfg(CFG_PLANE_X, plx);
    write_cfg(CFG_PLANE_Y, ply);
    cfg_we <= 1'b0;
    setups++;
  endtask

  initial begin
    col_ch.valid <= 1'b0;
    col_ch.column <= '0;
    sb.set_defaults();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset view, column extremes and center
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    send_column(0);
    send_column(1);
    send_column(511);
    send_column(512);
    send_column(513);
    send_column(1023);
    drain();
    // extreme positions, zero direction, zero ray on both axes at the center column
    load_setup('1, '1, '0, '0, POS_W'(65536), POS_W'(-65536));
    send_column(512);
    send_column(0);
    send_column(1023);
    drain();
    // large ray sums near the clamp, zero rays giving huge delta and side
    load_setup('0, POS_W'(1023) << 16, POS_W'(65536), POS_W'(-65536),
               POS_W'(65536), POS_W'(-65536));
    send_column(0);
    send_column(1023);
    send_column(512);
    drain();
    load_setup(POS_W'(32768), POS_W'(1), POS_W'(1), POS_W'(-1), '0, '0);
    send_column(0);
    send_column(700);
    drain();
    load_setup(POS_W'(5) << 16, POS_W'(7) << 16, POS_W'(-65536), POS_W'(65536),
               POS_W'(-65536), POS_W'(65536));
    send_column(0);
    send_column(1023);
    send_column(256);
    drain();

    // random phases: new setup, then a batch of columns with gaps and stalls
    in_gaps = 1'b1;
    out_stalls = 1'b1;
    for (int ph = 0; ph < 14; ph++) begin
      load_setup(rand_pos(), rand_pos(), rand_vec(), rand_vec(), rand_vec(), rand_vec());
      // every third phase runs without any idling
      in_gaps = (ph % 3 != 2);
      out_stalls = (ph % 3 != 2);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_column($urandom_range(0, 1) ? COL_W'(0) : COL_W'(1023));
        else
          send_column(COL_W'($urandom));
      end
      drain();
    end

    $display("covered %0d columns over %0d viewer setups, %0d ray words checked",
             cols_sent, setups, rays_seen);
    if (errors == 0) begin
      $display("PASS raycast_dda_setup_unit");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL raycast_dda_setup_unit");
    end
    $finish;
  end
endmodule
